// ===== hdl/mts_pkg.sv =====
// ----------------------------------------------------------------------------
// mts_pkg: shared definitions for the min tracking stack
// Sizes, transaction codes and the per-cell shift command.
// ----------------------------------------------------------------------------
package mts_pkg;

  // Stack size and derived widths
  localparam int DEPTH   = 64;
  localparam int COUNT_W = $clog2(DEPTH + 1);

  // Fixed field widths
  localparam int VAL_W   = 32;
  localparam int WORD_W  = VAL_W + 1;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 2;
  localparam int DEPTH_W = 7;

  // Operation codes carried in kind
  localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // Command broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP
  } cell_op_t;

  // Sign-extend a value into a stored word
  function automatic logic [WORD_W-1:0] widen(input logic [VAL_W-1:0] v);
    widen = {v[VAL_W-1], v};
  endfunction

endpackage

// ===== hdl/min_tracking_stack.sv =====
// ----------------------------------------------------------------------------
// min_tracking_stack: bounded stack of signed values with running minimum
// Shift-chain stack; the minimum is kept without a second stack.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries kind and value. A push
//   stores value, a pop removes the top, a peek (or undefined kind) reads
//   the top without change.
//   Output channel (out_valid / out_stall) returns one transaction per
//   input: status, data_value, min_value, min_valid and depth.
//   Each result is registered and shows in the cycle after acceptance.
//   Throughput: one transaction per cycle unless stalled. The entries
//   live in DEPTH chained cells that all shift up or down in the same
//   cycle; only the head cell, count and minimum feed the next operation.
//   Stall: while a result waits and out_stall is high, in_stall is high;
//   the result holds until taken and the stack does not change.
//   Reset: count and minimum clear to zero and the output goes empty; cell
//   contents are not cleared and no clearing pass is needed.
// ----------------------------------------------------------------------------
module min_tracking_stack
  import mts_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [KIND_W-1:0]  kind,
  input  logic signed [VAL_W-1:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [STAT_W-1:0]  status,
  output logic signed [VAL_W-1:0] data_value,
  output logic signed [VAL_W-1:0] min_value,
  output logic               min_valid,
  output logic [DEPTH_W-1:0] depth
);

  logic [COUNT_W-1:0] count, count_next;
  logic [VAL_W-1:0]   cur_min, cur_min_next;
  logic [WORD_W-1:0]  cell_word [DEPTH];
  logic [WORD_W-1:0]  push_word;
  logic [WORD_W-1:0]  top_diff;
  logic               top_enc;
  logic               is_empty, is_full, accept;
  cell_op_t           op;
  logic [STAT_W-1:0]  stat_c;
  logic [VAL_W-1:0]   data_c;

  // Input is taken unless a finished result is blocked
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign is_empty = (count == '0);
  assign is_full  = (count == COUNT_W'(DEPTH));

  // Head word is encoded when it sits below the minimum
  assign top_diff = cell_word[0] - widen(cur_min);
  assign top_enc  = top_diff[WORD_W-1];

  // Operation decode
  always_comb begin
    op           = CELL_HOLD;
    count_next   = count;
    cur_min_next = cur_min;
    push_word    = widen(value);
    stat_c       = STAT_OK;
    data_c       = '0;
    case (kind)
      KIND_PUSH: begin
        if (is_full) begin
          stat_c = STAT_FULL;
        end else begin
          op         = CELL_PUSH;
          count_next = count + 1'b1;
          if (is_empty) begin
            cur_min_next = value;
          end else if ($signed(value) < $signed(cur_min)) begin
            // store 2*value - min, modulo 2^33
            push_word    = {value, 1'b0} - widen(cur_min);
            cur_min_next = value;
          end
        end
      end
      default: begin
        // pop, peek and undefined kinds
        if (is_empty) begin
          stat_c = STAT_EMPTY;
        end else begin
          data_c = top_enc ? cur_min : cell_word[0][VAL_W-1:0];
          if (kind == KIND_POP) begin
            op         = CELL_POP;
            count_next = count - 1'b1;
            if (top_enc) begin
              cur_min_next = {cur_min[VAL_W-2:0], 1'b0} - cell_word[0][VAL_W-1:0];
            end
          end
        end
      end
    endcase
    if (!accept) begin
      op = CELL_HOLD;
    end
  end

  // Cell chain: cell 0 is the top of stack
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] above, below;
    if (i == 0) begin : g_head
      assign above = push_word;
    end else begin : g_body
      assign above = cell_word[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign below = '0;
    end else begin : g_inner
      assign below = cell_word[i+1];
    end
    mts_cell u_cell (
      .clk        (clk),
      .op         (op),
      .from_above (above),
      .from_below (below),
      .word       (cell_word[i])
    );
  end

  // Control state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cur_min   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        cur_min   <= cur_min_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status     <= stat_c;
      data_value <= data_c;
      min_value  <= (count_next != '0) ? cur_min_next : '0;
      min_valid  <= (count_next != '0);
      depth      <= DEPTH_W'(count_next);
    end
  end

endmodule

// ===== hdl/mts_cell.sv =====
// ----------------------------------------------------------------------------
// mts_cell: one entry of the shift stack
// Takes the word from the cell above on a push and from the cell below on
// a pop; holds otherwise.
// ----------------------------------------------------------------------------
module mts_cell
  import mts_pkg::*;
(
  input  logic              clk,
  input  cell_op_t          op,
  input  logic [WORD_W-1:0] from_above,
  input  logic [WORD_W-1:0] from_below,
  output logic [WORD_W-1:0] word
);

  // Entry register, no reset: contents are valid only below the count
  always_ff @(posedge clk) begin
    case (op)
      CELL_PUSH: word <= from_above;
      CELL_POP:  word <= from_below;
      default:   word <= word;
    endcase
  end

endmodule

// ===== hdl/mts_checker.sv =====
// ----------------------------------------------------------------------------
// mts_checker: port-level checks for the min tracking stack
// Watches the result channel; bound to the top level.
// ----------------------------------------------------------------------------
module mts_checker
  import mts_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [STAT_W-1:0]  status,
  input logic [VAL_W-1:0]   data_value,
  input logic [VAL_W-1:0]   min_value,
  input logic               min_valid,
  input logic [DEPTH_W-1:0] depth
);

  // A blocked result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data_value) && $stable(depth))
    else $error("stalled result changed");

  // Minimum is flagged exactly when entries remain
  a_min_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (min_valid == (depth != '0)))
    else $error("min_valid disagrees with depth");

  // An empty stack reports a zero minimum
  a_min_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !min_valid |-> min_value == '0)
    else $error("min_value nonzero on empty stack");

  // Refused push only at full depth
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_FULL |-> depth == DEPTH_W'(DEPTH))
    else $error("full status below capacity");

  // Refused pop or peek only when empty, and refusals report no data
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_EMPTY |-> depth == '0 && data_value == '0)
    else $error("empty status with entries present");

endmodule

bind min_tracking_stack mts_checker u_mts_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .status     (status),
  .data_value (data_value),
  .min_value  (min_value),
  .min_valid  (min_valid),
  .depth      (depth)
);
